### design/cbtr_pkg.sv
// cbtr_pkg: shared types and constants of the can block transfer receiver
`timescale 1ns / 1ps
package cbtr_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_SLOT  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_START_REQ_ID = 3'd0;
  localparam logic [2:0] REG_END_REQ_ID   = 3'd1;
  localparam logic [2:0] REG_START_ACK_ID = 3'd2;
  localparam logic [2:0] REG_END_ACK_ID   = 3'd3;
  localparam logic [2:0] REG_TRANSFER_TAG = 3'd4;
  localparam logic [2:0] REG_ACK_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_FRAME_TIMEOUT = 3'd6;

  // transfer phases
  localparam logic [2:0] PH_WAIT      = 3'd0;
  localparam logic [2:0] PH_START_ACK = 3'd1;
  localparam logic [2:0] PH_DATA      = 3'd2;
  localparam logic [2:0] PH_END_ACK   = 3'd3;
  localparam logic [2:0] PH_MISSING   = 3'd4;
  localparam logic [2:0] PH_SUCCESS   = 3'd5;
  localparam logic [2:0] PH_FAILED    = 3'd6;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_RD,
    ST_XOR,
    ST_SH,
    ST_CMP,
    ST_TMO,
    ST_DONE
  } cbtr_state_t;

  // control of the crc unit
  typedef struct packed {
    logic        init;
    logic        load;
    logic        shift;
    logic [31:0] word;
  } cbtr_crc_ctl_t;

endpackage

### design/can_block_transfer_receiver.sv
// can_block_transfer_receiver: top level, sequencer and transfer state
// Receiver side of a block transfer over CAN. One beat on the in_ channel is
// a received frame, a transmit slot or a millisecond tick (kind in in_tuser);
// every input beat yields exactly one result beat on the out_ channel with
// the offered ack and the transfer status after the item.
// Configuration writes go through cfg_valid/cfg_ready (always ready).
// A tick or a control frame goes straight to the done state; a data frame
// first stores its payload bytes (up to 7), one per cycle; a slot passes
// the timeout check before its result.
// An end-ack slot scans the frame bitmap one frame per cycle, then runs the
// crc unit over each 32-bit word (read, xor, four 8-bit shift steps).
// in_tready is high only while the sequencer is idle; one item at a time, the
// next one accepted once the previous result is in the output register.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a stalled out_tready holds the sequencer at its end.
// Reset (rst_n low, synchronous) clears phase, counters, bitmap, time and
// config to defaults; the payload store is not cleared.
`timescale 1ns / 1ps
module can_block_transfer_receiver #(
  parameter int MAX_FRAMES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // frame_id[28:0], frame_len[32:29], frame_data[96:33], tx_ready[97], pad
  input  logic [103:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], tx_valid[1], tx_id[30:2], tx_data[94:31], phase[97:95],
  // tries_left[105:98], crc_ok[106], pad
  output logic [111:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int STORE = MAX_FRAMES * 7;
  localparam int ROWS  = (STORE + 3) / 4;
  localparam int AW    = $clog2(STORE);
  localparam int CW    = $clog2(STORE + 1);
  localparam int IW    = $clog2(MAX_FRAMES);

  // input fields
  logic [28:0] in_id;
  logic [3:0]  in_len;
  logic [63:0] in_data;
  logic        in_rdy;
  assign in_id   = in_tdata[28:0];
  assign in_len  = in_tdata[32:29];
  assign in_data = in_tdata[96:33];
  assign in_rdy  = in_tdata[97];

  // configuration registers
  logic [28:0] start_req_id_r, end_req_id_r, start_ack_id_r, end_ack_id_r;
  logic [31:0] tag_r;
  logic [15:0] ack_tmo_r, frame_tmo_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_req_id_r <= '0;
      end_req_id_r   <= '0;
      start_ack_id_r <= '0;
      end_ack_id_r   <= '0;
      tag_r          <= '0;
      ack_tmo_r      <= 16'd1000;
      frame_tmo_r    <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbtr_pkg::REG_START_REQ_ID:  start_req_id_r <= cfg_data[28:0];
        cbtr_pkg::REG_END_REQ_ID:    end_req_id_r   <= cfg_data[28:0];
        cbtr_pkg::REG_START_ACK_ID:  start_ack_id_r <= cfg_data[28:0];
        cbtr_pkg::REG_END_ACK_ID:    end_ack_id_r   <= cfg_data[28:0];
        cbtr_pkg::REG_TRANSFER_TAG:  tag_r          <= cfg_data;
        cbtr_pkg::REG_ACK_TIMEOUT:   ack_tmo_r      <= cfg_data[15:0];
        cbtr_pkg::REG_FRAME_TIMEOUT: frame_tmo_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // state and control registers
  cbtr_pkg::cbtr_state_t state_r, state_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [7:0]            attempts_r, attempts_nxt;
  logic [31:0]           exp_crc_r, exp_crc_nxt;
  logic                  crc_match_r, crc_match_nxt;
  logic [MAX_FRAMES-1:0] bitmap_r, bitmap_nxt;
  logic [31:0]           now_r, now_nxt;
  logic [31:0]           deadline_r, deadline_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // per-item working registers
  logic                  acc_r, acc_nxt;
  logic                  sent_r, sent_nxt;
  logic [28:0]           txid_r, txid_nxt;
  logic [63:0]           txd_r, txd_nxt;
  logic [63:0]           data_r, data_nxt;
  logic                  rdy_r, rdy_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [2:0]            nb_r, nb_nxt;
  logic [IW:0]           i_r, i_nxt;
  logic [CW:0]           pos_r, pos_nxt;
  logic [AW-3:0]         w_r, w_nxt;
  logic [CW:0]           bpos_r, bpos_nxt;
  logic [1:0]            sh_r, sh_nxt;
  logic [111:0]          out_r, out_nxt;

  // memory and crc unit hookup
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [7:0]              mem_wdata;
  logic [31:0]             mem_rdata;
  logic [31:0]             crc;
  cbtr_pkg::cbtr_crc_ctl_t crc_ctl;

  cbtr_payload_ram #(.AW(AW), .ROWS(ROWS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (w_r),
    .rdata (mem_rdata)
  );

  cbtr_crc_unit u_crc (
    .clk (clk),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // sequencer: next state and datapath control
  always_comb begin
    logic [15:0]   sz;
    logic [31:0]   dl;
    logic [7:0]    att;
    logic [31:0]   mword;
    logic [63:0]   shd;
    logic          match;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    attempts_nxt  = attempts_r;
    exp_crc_nxt   = exp_crc_r;
    crc_match_nxt = crc_match_r;
    bitmap_nxt    = bitmap_r;
    now_nxt       = now_r;
    deadline_nxt  = deadline_r;
    out_valid_nxt = out_valid_r && !out_tready;
    acc_nxt       = acc_r;
    sent_nxt      = sent_r;
    txid_nxt      = txid_r;
    txd_nxt       = txd_r;
    data_nxt      = data_r;
    rdy_nxt       = rdy_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    nb_nxt        = nb_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    w_nxt         = w_r;
    bpos_nxt      = bpos_r;
    sh_nxt        = sh_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = base_r + AW'(k_r);
    shd           = data_r >> {k_r + 3'd1, 3'b000};
    mem_wdata     = shd[7:0];
    crc_ctl       = '0;
    sz            = in_data[47:32];
    dl            = sent_r ? (now_r + 32'(ack_tmo_r)) : deadline_r;
    att           = attempts_r - 8'd1;
    match         = (crc == exp_crc_r);
    for (int b = 0; b < 4; b++) begin
      mword[8*b +: 8] = ((bpos_r + (CW+1)'(b)) < {1'b0, count_r}) ?
                        mem_rdata[8*b +: 8] : 8'h00;
    end
    crc_ctl.word  = mword;

    case (state_r)
      cbtr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          acc_nxt  = 1'b0;
          sent_nxt = 1'b0;
          txid_nxt = '0;
          txd_nxt  = '0;
          data_nxt = in_data;
          rdy_nxt  = in_rdy;
          state_nxt = cbtr_pkg::ST_DONE;
          case (in_tuser)
            cbtr_pkg::CMD_FRAME: begin
              if (phase_r == cbtr_pkg::PH_WAIT && in_id == start_req_id_r) begin
                bitmap_nxt   = '0;
                count_nxt    = (32'(sz) > 32'(STORE)) ? CW'(STORE) : CW'(sz);
                attempts_nxt = in_data[55:48];
                phase_nxt    = cbtr_pkg::PH_START_ACK;
                acc_nxt      = 1'b1;
              end else if (in_id == end_req_id_r) begin
                exp_crc_nxt = in_data[63:32];
                phase_nxt   = cbtr_pkg::PH_END_ACK;
                acc_nxt     = 1'b1;
              end else if (phase_r == cbtr_pkg::PH_DATA ||
                           phase_r == cbtr_pkg::PH_MISSING) begin
                acc_nxt = 1'b1;
                if ({1'b0, in_data[7:0]} < 9'(MAX_FRAMES)) begin
                  bitmap_nxt[in_data[IW-1:0]] = 1'b1;
                  base_nxt = AW'({in_data[7:0], 3'b000}) - AW'(in_data[7:0]);
                  k_nxt    = '0;
                  if (in_len == 4'd0) begin
                    nb_nxt = 3'd0;
                  end else if (in_len > 4'd8) begin
                    nb_nxt = 3'd7;
                  end else begin
                    nb_nxt = 3'(in_len - 4'd1);
                  end
                  if (nb_nxt != 3'd0) begin
                    state_nxt = cbtr_pkg::ST_WRITE;
                  end
                end
              end
              if (acc_nxt) begin
                deadline_nxt = now_r + 32'(frame_tmo_r);
              end
            end
            cbtr_pkg::CMD_SLOT: begin
              state_nxt = cbtr_pkg::ST_TMO;
              if (phase_r == cbtr_pkg::PH_START_ACK) begin
                txid_nxt = start_ack_id_r;
                txd_nxt  = {8'h00, attempts_r, 16'(count_r), tag_r};
                if (in_rdy) begin
                  sent_nxt  = 1'b1;
                  phase_nxt = cbtr_pkg::PH_DATA;
                end
              end else if (phase_r == cbtr_pkg::PH_END_ACK) begin
                txid_nxt  = end_ack_id_r;
                txd_nxt   = {32'h0, tag_r};
                i_nxt     = '0;
                pos_nxt   = '0;
                state_nxt = cbtr_pkg::ST_SCAN;
              end
            end
            cbtr_pkg::CMD_TICK: begin
              now_nxt = now_r + 32'd1;
            end
            default: ;
          endcase
        end
      end

      // one payload byte per cycle
      cbtr_pkg::ST_WRITE: begin
        mem_we = 1'b1;
        k_nxt  = k_r + 3'd1;
        if (k_r + 3'd1 == nb_r) begin
          state_nxt = cbtr_pkg::ST_DONE;
        end
      end

      // first missing frame, one bitmap bit per cycle
      cbtr_pkg::ST_SCAN: begin
        if (pos_r < {1'b0, count_r}) begin
          if (!bitmap_r[i_r[IW-1:0]]) begin
            txd_nxt[32]    = 1'b1;
            txd_nxt[47:40] = 8'(i_r[IW-1:0]);
            if (rdy_r) begin
              sent_nxt  = 1'b1;
              phase_nxt = cbtr_pkg::PH_MISSING;
            end
            state_nxt = cbtr_pkg::ST_TMO;
          end else begin
            i_nxt   = i_r + (IW+1)'(1);
            pos_nxt = pos_r + (CW+1)'(7);
          end
        end else begin
          crc_ctl.init = 1'b1;
          w_nxt        = '0;
          bpos_nxt     = '0;
          state_nxt    = cbtr_pkg::ST_RD;
        end
      end

      // crc walk: read word, xor, four byte shifts
      cbtr_pkg::ST_RD: begin
        state_nxt = (bpos_r < {1'b0, count_r}) ? cbtr_pkg::ST_XOR : cbtr_pkg::ST_CMP;
      end
      cbtr_pkg::ST_XOR: begin
        crc_ctl.load = 1'b1;
        sh_nxt       = '0;
        state_nxt    = cbtr_pkg::ST_SH;
      end
      cbtr_pkg::ST_SH: begin
        crc_ctl.shift = 1'b1;
        sh_nxt        = sh_r + 2'd1;
        if (sh_r == 2'd3) begin
          w_nxt     = w_r + (AW-2)'(1);
          bpos_nxt  = bpos_r + (CW+1)'(4);
          state_nxt = cbtr_pkg::ST_RD;
        end
      end
      cbtr_pkg::ST_CMP: begin
        crc_match_nxt = match;
        txd_nxt[48]   = match;
        if (rdy_r) begin
          sent_nxt = 1'b1;
          if (match) begin
            phase_nxt = cbtr_pkg::PH_SUCCESS;
          end else begin
            attempts_nxt = att;
            phase_nxt    = (att != 8'd0) ? cbtr_pkg::PH_WAIT : cbtr_pkg::PH_FAILED;
          end
        end
        state_nxt = cbtr_pkg::ST_TMO;
      end

      // ack deadline and timeout check at the end of a slot
      cbtr_pkg::ST_TMO: begin
        deadline_nxt = dl;
        if (now_r > dl) begin
          attempts_nxt = att;
          phase_nxt    = (att != 8'd0) ? cbtr_pkg::PH_WAIT : cbtr_pkg::PH_FAILED;
        end
        acc_nxt   = sent_r;
        state_nxt = cbtr_pkg::ST_DONE;
      end

      // result into the output register
      cbtr_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt = {5'd0, crc_match_r, attempts_r, phase_r, txd_r, txid_r,
                     sent_r, acc_r};
          out_valid_nxt = 1'b1;
          state_nxt     = cbtr_pkg::ST_IDLE;
        end
      end

      default: state_nxt = cbtr_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbtr_pkg::ST_IDLE;
      phase_r     <= cbtr_pkg::PH_WAIT;
      count_r     <= '0;
      attempts_r  <= '0;
      exp_crc_r   <= '0;
      crc_match_r <= 1'b0;
      bitmap_r    <= '0;
      now_r       <= '0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      attempts_r  <= attempts_nxt;
      exp_crc_r   <= exp_crc_nxt;
      crc_match_r <= crc_match_nxt;
      bitmap_r    <= bitmap_nxt;
      now_r       <= now_nxt;
      deadline_r  <= deadline_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sent_r <= sent_nxt;
    txid_r <= txid_nxt;
    txd_r  <= txd_nxt;
    data_r <= data_nxt;
    rdy_r  <= rdy_nxt;
    base_r <= base_nxt;
    k_r    <= k_nxt;
    nb_r   <= nb_nxt;
    i_r    <= i_nxt;
    pos_r  <= pos_nxt;
    w_r    <= w_nxt;
    bpos_r <= bpos_nxt;
    sh_r   <= sh_nxt;
    out_r  <= out_nxt;
  end

  assign in_tready  = (state_r == cbtr_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // an accepted item leaves the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer ready right after accepting an item");

  // the end-ack walk runs only in the end-ack phase
  a_walk_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbtr_pkg::ST_SCAN || state_r == cbtr_pkg::ST_RD ||
     state_r == cbtr_pkg::ST_XOR || state_r == cbtr_pkg::ST_SH)
    |-> phase_r == cbtr_pkg::PH_END_ACK)
    else $error("crc walk outside end-ack phase");

  // payload bytes are written only while taking data
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (phase_r == cbtr_pkg::PH_DATA || phase_r == cbtr_pkg::PH_MISSING))
    else $error("payload write outside data phase");

  // a reported phase is always a defined one
  a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[97:95] != 3'd7)
    else $error("undefined phase reported");

endmodule

### design/cbtr_crc_unit.sv
// cbtr_crc_unit: crc-32/mpeg-2 register, word xor and eight-bit shift step
`timescale 1ns / 1ps
module cbtr_crc_unit (
  input  logic                   clk,
  input  cbtr_pkg::cbtr_crc_ctl_t ctl,
  output logic [31:0]            crc
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] sh;

  // eight msb-first shift steps per cycle
  always_comb begin
    sh = crc_r;
    for (int b = 0; b < 8; b++) begin
      sh = sh[31] ? ((sh << 1) ^ cbtr_pkg::CRC_POLY) : (sh << 1);
    end
    crc_nxt = crc_r;
    if (ctl.init) begin
      crc_nxt = cbtr_pkg::CRC_INIT;
    end else if (ctl.load) begin
      crc_nxt = crc_r ^ ctl.word;
    end else if (ctl.shift) begin
      crc_nxt = sh;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

### design/cbtr_payload_ram.sv
// cbtr_payload_ram: payload store as four byte lanes, byte write, word read
`timescale 1ns / 1ps
module cbtr_payload_ram #(
  parameter int AW   = 11,
  parameter int ROWS = 448
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-3:0] raddr,
  output logic [31:0]   rdata
);

  logic [7:0] lane0 [ROWS];
  logic [7:0] lane1 [ROWS];
  logic [7:0] lane2 [ROWS];
  logic [7:0] lane3 [ROWS];
  logic [31:0] rdata_r;

  // byte write into the lane picked by the low address bits
  always_ff @(posedge clk) begin
    if (we) begin
      case (waddr[1:0])
        2'd0: lane0[waddr[AW-1:2]] <= wdata;
        2'd1: lane1[waddr[AW-1:2]] <= wdata;
        2'd2: lane2[waddr[AW-1:2]] <= wdata;
        default: lane3[waddr[AW-1:2]] <= wdata;
      endcase
    end
  end

  // registered little-endian word read
  always_ff @(posedge clk) begin
    rdata_r <= {lane3[raddr], lane2[raddr], lane1[raddr], lane0[raddr]};
  end

  assign rdata = rdata_r;

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for the can block transfer receiver
`timescale 1ns / 1ps
module testbench;

  localparam int STORE_BYTES = 1792;
  localparam int STALL_LIMIT = 20000;

  // one result beat as packed on out_tdata (lowest field last)
  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  tries;
    logic [2:0]  phase;
    logic [63:0] tx_data;
    logic [28:0] tx_id;
    logic        tx_valid;
    logic        accepted;
  } status_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  can_block_transfer_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver model: registers
  logic [28:0] reg_start_req, reg_end_req, reg_start_ack, reg_end_ack;
  logic [31:0] reg_tag;
  logic [15:0] reg_ack_tmo, reg_frame_tmo;
  // receiver model: transfer state
  logic [2:0]  xfer_phase;
  logic [10:0] xfer_bytes;
  logic [7:0]  tries;
  logic [31:0] crc_expect;
  logic        crc_hit;
  bit [255:0]  frame_seen;
  logic [7:0]  payload [STORE_BYTES];
  bit          written [STORE_BYTES];
  logic [31:0] clock_ms, due_ms;

  status_t status_q[$];
  int      errors = 0;
  int      item_count = 0;
  bit      calm = 0;
  bit      hold_req = 0;

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function automatic int first_missing();
    int frames;
    frames = (int'(xfer_bytes) + 6) / 7;
    if (frames > 256) frames = 256;
    for (int i = 0; i < frames; i++)
      if (!frame_seen[i]) return i;
    return -1;
  endfunction

  // crc-32/mpeg-2 over little-endian words of the payload
  function automatic logic [31:0] payload_crc32();
    logic [31:0] c, w;
    c = cbtr_pkg::CRC_INIT;
    for (int p = 0; p < int'(xfer_bytes); p += 4) begin
      w = '0;
      for (int b = 0; b < 4; b++)
        if (p + b < int'(xfer_bytes)) w[8*b +: 8] = payload[p + b];
      c ^= w;
      repeat (32) c = c[31] ? ((c << 1) ^ cbtr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // an end ack over bytes never stored is out of contract
  function automatic bit check_hits_unwritten();
    if (xfer_phase != cbtr_pkg::PH_END_ACK || first_missing() >= 0) return 0;
    for (int i = 0; i < int'(xfer_bytes); i++)
      if (!written[i]) return 1;
    return 0;
  endfunction

  function automatic void burn_try();
    tries = tries - 8'd1;
    xfer_phase = (tries != 0) ? cbtr_pkg::PH_WAIT : cbtr_pkg::PH_FAILED;
  endfunction

  // predicted status after one item
  function automatic status_t step_receiver(logic [1:0] cmd, logic [28:0] fid,
                                            logic [3:0] flen, logic [63:0] fd,
                                            logic rdy);
    status_t r;
    int miss, n, idx;
    logic [15:0] sz;
    r = '0;
    case (cmd)
      cbtr_pkg::CMD_FRAME: begin
        if (xfer_phase == cbtr_pkg::PH_WAIT && fid == reg_start_req) begin
          sz = fd[47:32];
          frame_seen = '0;
          xfer_bytes = (sz > STORE_BYTES) ? 11'(STORE_BYTES) : sz[10:0];
          tries = fd[55:48];
          xfer_phase = cbtr_pkg::PH_START_ACK;
          r.accepted = 1;
        end else if (fid == reg_end_req) begin
          crc_expect = fd[63:32];
          xfer_phase = cbtr_pkg::PH_END_ACK;
          r.accepted = 1;
        end else if (xfer_phase == cbtr_pkg::PH_DATA ||
                     xfer_phase == cbtr_pkg::PH_MISSING) begin
          idx = int'(fd[7:0]);
          frame_seen[idx] = 1;
          n = (flen == 0) ? 0 : ((flen > 8) ? 7 : int'(flen) - 1);
          for (int i = 0; i < n; i++) begin
            payload[idx*7 + i] = fd[8*(i+1) +: 8];
            written[idx*7 + i] = 1;
          end
          r.accepted = 1;
        end
        if (r.accepted) due_ms = clock_ms + 32'(reg_frame_tmo);
      end
      cbtr_pkg::CMD_SLOT: begin
        if (xfer_phase == cbtr_pkg::PH_START_ACK) begin
          r.tx_id = reg_start_ack;
          r.tx_data = {8'h00, tries, 5'b0, xfer_bytes, reg_tag};
          if (rdy) begin
            r.tx_valid = 1;
            xfer_phase = cbtr_pkg::PH_DATA;
          end
        end else if (xfer_phase == cbtr_pkg::PH_END_ACK) begin
          miss = first_missing();
          r.tx_id = reg_end_ack;
          r.tx_data = {32'h0, reg_tag};
          if (miss >= 0) begin
            r.tx_data[32] = 1'b1;
            r.tx_data[47:40] = miss[7:0];
            if (rdy) begin
              r.tx_valid = 1;
              xfer_phase = cbtr_pkg::PH_MISSING;
            end
          end else begin
            crc_hit = (payload_crc32() == crc_expect);
            r.tx_data[48] = crc_hit;
            if (rdy) begin
              r.tx_valid = 1;
              if (crc_hit) xfer_phase = cbtr_pkg::PH_SUCCESS;
              else burn_try();
            end
          end
        end
        if (r.tx_valid) due_ms = clock_ms + 32'(reg_ack_tmo);
        if (clock_ms > due_ms) burn_try();
        r.accepted = r.tx_valid;
      end
      cbtr_pkg::CMD_TICK: clock_ms = clock_ms + 32'd1;
      default: ;
    endcase
    r.phase = xfer_phase;
    r.tries = tries;
    r.crc_ok = crc_hit;
    return r;
  endfunction

  // one input beat, predicted at acceptance
  task automatic send_item(logic [1:0] cmd, logic [28:0] fid, logic [3:0] flen,
                           logic [63:0] fd, logic rdy);
    if (cmd == cbtr_pkg::CMD_SLOT && check_hits_unwritten()) cmd = cbtr_pkg::CMD_TICK;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'b0, rdy, fd, flen, fid};
    do @(posedge clk); while (!in_tready);
    status_q.push_back(step_receiver(cmd, fid, flen, fd, rdy));
    item_count++;
  endtask

  task automatic send_frame(logic [28:0] fid, logic [3:0] flen, logic [63:0] fd);
    send_item(cbtr_pkg::CMD_FRAME, fid, flen, fd, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_slot(logic rdy);
    send_item(cbtr_pkg::CMD_SLOT, 29'($urandom), 4'($urandom), {$urandom, $urandom},
              rdy);
  endtask

  task automatic send_tick();
    send_item(cbtr_pkg::CMD_TICK, 29'($urandom), 4'($urandom), {$urandom, $urandom},
              1'($urandom_range(0, 1)));
  endtask

  // register write, only once every result is in
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (status_q.size() == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cbtr_pkg::REG_START_REQ_ID:  reg_start_req = val[28:0];
      cbtr_pkg::REG_END_REQ_ID:    reg_end_req = val[28:0];
      cbtr_pkg::REG_START_ACK_ID:  reg_start_ack = val[28:0];
      cbtr_pkg::REG_END_ACK_ID:    reg_end_ack = val[28:0];
      cbtr_pkg::REG_TRANSFER_TAG:  reg_tag = val;
      cbtr_pkg::REG_ACK_TIMEOUT:   reg_ack_tmo = val[15:0];
      cbtr_pkg::REG_FRAME_TIMEOUT: reg_frame_tmo = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [28:0] data_id();
    logic [28:0] id;
    id = 29'($urandom);
    while (id == reg_start_req || id == reg_end_req) id = id + 29'd1;
    return id;
  endfunction

  function automatic logic [63:0] start_beat(logic [15:0] sz, logic [7:0] n_tries);
    logic [63:0] fd;
    fd = {$urandom, $urandom};
    fd[47:32] = sz;
    fd[55:48] = n_tries;
    return fd;
  endfunction

  // run timeouts until the transfer is back to waiting for a start
  task automatic settle_idle();
    int g;
    g = 0;
    while (xfer_phase != cbtr_pkg::PH_WAIT && g < 4) begin
      send_frame(reg_end_req, 4'd8, {$urandom, $urandom});
      while (clock_ms <= due_ms) send_tick();
      send_slot(1'b0);
      if (xfer_phase != cbtr_pkg::PH_WAIT) send_slot(1'b0);
      g++;
    end
  endtask

  // one well-formed transfer with random content, drops and corruption
  task automatic transfer_round();
    int sz, frames, tmp, j, g;
    int order[$];
    logic [63:0] fd;
    settle_idle();
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom_range(0, 3)), 29'($urandom), 4'($urandom),
                  {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
    send_frame(reg_start_req, 4'($urandom_range(1, 15)),
               start_beat(16'(sz),
                          ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255))));
    g = 0;
    while (xfer_phase == cbtr_pkg::PH_START_ACK && g < 10) begin
      send_slot($urandom_range(0, 3) != 0);
      g++;
    end
    frames = (int'(xfer_bytes) + 6) / 7;
    if (frames > 12) frames = $urandom_range(1, 6);
    for (int i = 0; i < frames; i++) order.push_back(i);
    for (int i = frames - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (frames > 0 && $urandom_range(0, 4) == 0) void'(order.pop_back());
    foreach (order[k]) begin
      if ($urandom_range(0, 5) == 0) send_tick();
      fd = {$urandom, $urandom};
      fd[7:0] = 8'(order[k]);
      send_frame(data_id(), ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd8, fd);
    end
    g = 0;
    while (g < 8 && xfer_phase != cbtr_pkg::PH_SUCCESS &&
           xfer_phase != cbtr_pkg::PH_FAILED) begin
      if (xfer_phase == cbtr_pkg::PH_MISSING) begin
        fd = {$urandom, $urandom};
        fd[7:0] = 8'(first_missing());
        send_frame(data_id(), 4'd8, fd);
      end
      if (xfer_phase != cbtr_pkg::PH_END_ACK) begin
        fd = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) fd[63:32] = payload_crc32();
        send_frame(reg_end_req, 4'($urandom_range(1, 8)), fd);
      end
      send_slot($urandom_range(0, 4) != 0);
      if (xfer_phase == cbtr_pkg::PH_WAIT) g = 8;
      g++;
    end
  endtask

  // ids, idle commands and frames ignored while waiting
  task automatic test_registers_idle();
    write_reg(cbtr_pkg::REG_START_REQ_ID, 32'h1FFF_FFFF);
    write_reg(cbtr_pkg::REG_END_REQ_ID, 32'h0000_0000);
    write_reg(cbtr_pkg::REG_START_ACK_ID, 32'h1FFF_FFFF);
    write_reg(cbtr_pkg::REG_END_ACK_ID, 32'h0000_0001);
    write_reg(cbtr_pkg::REG_TRANSFER_TAG, 32'hFFFF_FFFF);
    write_reg(cbtr_pkg::REG_ACK_TIMEOUT, 32'd2);
    write_reg(cbtr_pkg::REG_FRAME_TIMEOUT, 32'd2);
    send_item(2'd3, '1, '1, '1, 1'b1);
    send_tick();
    send_slot(1'b1);
    send_frame(29'h123, 4'd8, '1);
  endtask

  // clamp, ack held back, frame lengths, missing frame, timeout, crc pass/fail
  task automatic test_directed_transfer();
    send_frame(reg_start_req, 4'd8, start_beat(16'hFFFF, 8'd0));
    send_slot(1'b0);
    send_slot(1'b1);
    send_frame(29'h0AB_CDEF, 4'd15, 64'hFFEE_DDCC_BBAA_9900);
    send_frame(29'h0AB_CDEF, 4'd0, 64'h0000_0000_0000_0001);
    send_frame(29'h0AB_CDEF, 4'd8, 64'h1122_3344_5566_77FF);
    send_frame(reg_end_req, 4'd8, 64'h0);
    send_slot(1'b1);
    repeat (3) send_tick();
    send_slot(1'b1);
    send_frame(reg_start_req, 4'd8, start_beat(16'd0, 8'd1));
    send_slot(1'b1);
    send_frame(reg_end_req, 4'd8, {32'hFFFF_FFFF, 32'h0});
    send_slot(1'b1);
    send_frame(reg_end_req, 4'd8, {32'h1234_5678, 32'h0});
    send_slot(1'b1);
    settle_idle();
  endtask

  // largest transfer: every frame, crc over the whole store
  task automatic test_full_store();
    logic [63:0] fd;
    write_reg(cbtr_pkg::REG_ACK_TIMEOUT, 32'd65535);
    write_reg(cbtr_pkg::REG_FRAME_TIMEOUT, 32'd65535);
    send_frame(reg_start_req, 4'd8, start_beat(16'd1792, 8'($urandom_range(1, 255))));
    send_slot(1'b1);
    for (int i = 0; i < 256; i++) begin
      fd = {$urandom, $urandom};
      fd[7:0] = 8'(i);
      send_frame(data_id(), 4'd8, fd);
    end
    send_frame(reg_end_req, 4'd8, {payload_crc32(), 32'h0});
    send_slot(1'b1);
    write_reg(cbtr_pkg::REG_ACK_TIMEOUT, 32'd0);
    write_reg(cbtr_pkg::REG_FRAME_TIMEOUT, 32'd0);
  endtask

  // output held off long enough to back up the input
  task automatic test_backpressure();
    hold_req = 1;
    repeat (20) send_tick();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (!hold_req);
  endtask

  // random transfers under changing settings
  task automatic test_random_transfers(int until_items);
    while (item_count < until_items) begin
      if ($urandom_range(0, 5) == 0) begin
        write_reg(cbtr_pkg::REG_START_REQ_ID, $urandom);
        write_reg(cbtr_pkg::REG_END_REQ_ID, $urandom);
        write_reg(cbtr_pkg::REG_START_ACK_ID, $urandom);
        write_reg(cbtr_pkg::REG_END_ACK_ID, $urandom);
        write_reg(cbtr_pkg::REG_TRANSFER_TAG, $urandom);
        write_reg(cbtr_pkg::REG_ACK_TIMEOUT, 32'($urandom_range(0, 20)));
        write_reg(cbtr_pkg::REG_FRAME_TIMEOUT, 32'($urandom_range(0, 20)));
      end
      transfer_round();
    end
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    status_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[106:0];
      if (status_q.size() == 0) begin
        flag_error("result beat with no prediction pending");
      end else begin
        want = status_q.pop_front();
        if (got.accepted !== want.accepted)
          flag_error($sformatf("accepted %0b want %0b", got.accepted, want.accepted));
        if (got.tx_valid !== want.tx_valid)
          flag_error($sformatf("tx_valid %0b want %0b", got.tx_valid, want.tx_valid));
        if (got.tx_id !== want.tx_id)
          flag_error($sformatf("tx_id %h want %h", got.tx_id, want.tx_id));
        if (got.tx_data !== want.tx_data)
          flag_error($sformatf("tx_data %h want %h", got.tx_data, want.tx_data));
        if (got.phase !== want.phase)
          flag_error($sformatf("phase %0d want %0d", got.phase, want.phase));
        if (got.tries !== want.tries)
          flag_error($sformatf("tries_left %0d want %0d", got.tries, want.tries));
        if (got.crc_ok !== want.crc_ok)
          flag_error($sformatf("crc_ok %0b want %0b", got.crc_ok, want.crc_ok));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    reg_start_req = '0; reg_end_req = '0; reg_start_ack = '0; reg_end_ack = '0;
    reg_tag = '0; reg_ack_tmo = 16'd1000; reg_frame_tmo = 16'd1000;
    xfer_phase = cbtr_pkg::PH_WAIT; xfer_bytes = '0; tries = '0; crc_expect = '0;
    crc_hit = 0; frame_seen = '0; clock_ms = '0; due_ms = '0;
    foreach (payload[i]) begin
      payload[i] = '0;
      written[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_registers_idle();
    test_directed_transfer();
    test_full_store();
    test_backpressure();
    test_random_transfers(500);
    calm = 1;
    test_random_transfers(550);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (status_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/cbtr_pkg.sv
design/cbtr_crc_unit.sv
design/cbtr_payload_ram.sv
design/can_block_transfer_receiver.sv
tb/sv/testbench.sv
